@@ sv/descriptor_slot_table_core_macros.svh @@
// assertion helpers for the descriptor slot table
`ifndef DESCRIPTOR_SLOT_TABLE_CORE_MACROS_SVH
`define DESCRIPTOR_SLOT_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dst_pkg.sv @@
`timescale 1ns / 1ps

package dst_pkg;

    localparam int NUM_SLOTS    = 64;
    localparam int HANDLE_WIDTH = 32;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int HINT_W       = $clog2(NUM_SLOTS + 1);

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_LOOKUP  = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2,
        STAT_NONE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_CLR_FIND
    } state_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } enc_result_t;

endpackage

@@ sv/dst_slot_ram.sv @@
`timescale 1ns / 1ps

module dst_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/dst_prio_enc.sv @@
`timescale 1ns / 1ps

module dst_prio_enc (
    input  logic [dst_pkg::NUM_SLOTS-1:0] req,
    output dst_pkg::enc_result_t          res
);

    // lowest set bit wins
    always_comb
    begin
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = dst_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (req[i])
            begin
                res.found = 1'b1;
                res.idx   = dst_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

@@ sv/descriptor_slot_table_core.sv @@
// a request is accepted only in the idle state and held in the pending registers; its
// result, with any handle read from slot memory, loads into the output register when free
// clear-all alternates find and response states, one held slot per result, lowest first
// no new request is accepted until the previous result (all of a clear-all) has loaded
// reset: occupancy, hint and output valid clear at once; the slot memory is not cleared
// and is read only for occupied slots, so no clearing pass is needed
`timescale 1ns / 1ps

`include "descriptor_slot_table_core_macros.svh"

module descriptor_slot_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  slot,
    input  logic [31:0] handle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  slot_out,
    output logic [31:0] handle_out,
    output logic        last
);

    localparam int NS = dst_pkg::NUM_SLOTS;
    localparam int HW = dst_pkg::HANDLE_WIDTH;
    localparam int SW = dst_pkg::SLOT_W;
    localparam int TW = dst_pkg::HINT_W;

    dst_pkg::state_t  state_reg, state_next;
    logic [NS-1:0]    occ_reg, occ_next;
    logic [TW-1:0]    hint_reg, hint_next;
    logic             out_valid_reg, out_valid_next;

    dst_pkg::status_t pend_status_reg, pend_status_next;
    logic [SW-1:0]    pend_slot_reg, pend_slot_next;
    logic [7:0]       pend_slot8_reg, pend_slot8_next;
    logic [HW-1:0]    pend_handle_reg, pend_handle_next;
    logic             pend_rdata_reg, pend_rdata_next;
    logic             pend_last_reg, pend_last_next;
    logic             pend_clear_reg, pend_clear_next;

    dst_pkg::status_t status_reg, status_next;
    logic [7:0]       slot_out_reg, slot_out_next;
    logic [31:0]      handle_out_reg, handle_out_next;
    logic             last_reg, last_next;

    logic [NS-1:0]    hint_mask;
    dst_pkg::enc_result_t free_res, held_res;

    logic             ram_we, ram_re;
    logic [SW-1:0]    ram_waddr, ram_raddr;
    logic [HW-1:0]    ram_wdata, ram_rdata;

    logic             in_fire, out_free, in_range;
    logic [HW-1:0]    in_handle;
    logic [SW-1:0]    in_idx;

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            hint_mask[i] = (TW'(i) >= hint_reg);
        end
    end

    dst_prio_enc u_free_enc (
        .req (~occ_reg & hint_mask),
        .res (free_res)
    );

    dst_prio_enc u_held_enc (
        .req (occ_reg),
        .res (held_res)
    );

    dst_slot_ram #(
        .DEPTH (NS),
        .WIDTH (HW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_range  = (slot < 8'(NS));
    assign in_handle = HW'(handle);
    assign in_idx    = slot[SW-1:0];

    always_comb
    begin
        state_next       = state_reg;
        occ_next         = occ_reg;
        hint_next        = hint_reg;
        out_valid_next   = out_valid_reg && out_stall;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_slot8_next  = pend_slot8_reg;
        pend_handle_next = pend_handle_reg;
        pend_rdata_next  = pend_rdata_reg;
        pend_last_next   = pend_last_reg;
        pend_clear_next  = pend_clear_reg;
        status_next      = status_reg;
        slot_out_next    = slot_out_reg;
        handle_out_next  = handle_out_reg;
        last_next        = last_reg;
        in_stall         = 1'b1;
        ram_we           = 1'b0;
        ram_waddr        = free_res.idx;
        ram_wdata        = in_handle;
        ram_re           = 1'b0;
        ram_raddr        = in_idx;

        case (state_reg)
            dst_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    pend_slot8_next  = slot;
                    pend_handle_next = '0;
                    pend_rdata_next  = 1'b0;
                    pend_last_next   = 1'b1;
                    pend_clear_next  = 1'b0;
                    pend_status_next = dst_pkg::STAT_BAD;
                    state_next       = dst_pkg::ST_RESP;
                    case (action)
                        dst_pkg::ACT_ALLOC:
                        begin
                            pend_slot8_next = '0;
                            if (in_handle == '0)
                            begin
                                pend_status_next = dst_pkg::STAT_BAD;
                            end
                            else if (!free_res.found)
                            begin
                                pend_status_next = dst_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we           = 1'b1;
                                occ_next         = occ_reg | (NS'(1) << free_res.idx);
                                hint_next        = TW'(free_res.idx) + TW'(1);
                                pend_status_next = dst_pkg::STAT_OK;
                                pend_slot8_next  = 8'(free_res.idx);
                                pend_handle_next = in_handle;
                            end
                        end
                        dst_pkg::ACT_RELEASE:
                        begin
                            if (in_range)
                            begin
                                if (hint_reg > TW'(in_idx))
                                begin
                                    hint_next = TW'(in_idx);
                                end
                                if (occ_reg[in_idx])
                                begin
                                    ram_re           = 1'b1;
                                    occ_next         = occ_reg & ~(NS'(1) << in_idx);
                                    pend_status_next = dst_pkg::STAT_OK;
                                    pend_rdata_next  = 1'b1;
                                end
                            end
                        end
                        dst_pkg::ACT_LOOKUP:
                        begin
                            if (in_range && occ_reg[in_idx])
                            begin
                                ram_re           = 1'b1;
                                pend_status_next = dst_pkg::STAT_OK;
                                pend_rdata_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            pend_slot8_next = '0;
                            if (held_res.found)
                            begin
                                state_next = dst_pkg::ST_CLR_FIND;
                            end
                            else
                            begin
                                pend_status_next = dst_pkg::STAT_NONE;
                            end
                        end
                    endcase
                end
            end
            dst_pkg::ST_CLR_FIND:
            begin
                // pick the lowest held slot, read it and drop it from the table
                ram_re           = 1'b1;
                ram_raddr        = held_res.idx;
                occ_next         = occ_reg & ~(NS'(1) << held_res.idx);
                pend_status_next = dst_pkg::STAT_OK;
                pend_slot_next   = held_res.idx;
                pend_slot8_next  = 8'(held_res.idx);
                pend_rdata_next  = 1'b1;
                pend_last_next   = (occ_next == '0);
                pend_clear_next  = 1'b1;
                state_next       = dst_pkg::ST_RESP;
            end
            dst_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = pend_status_reg;
                    slot_out_next   = pend_slot8_reg;
                    handle_out_next = pend_rdata_reg ? 32'(ram_rdata) : 32'(pend_handle_reg);
                    last_next       = pend_last_reg;
                    if (pend_clear_reg && !pend_last_reg)
                    begin
                        state_next = dst_pkg::ST_CLR_FIND;
                    end
                    else
                    begin
                        state_next = dst_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dst_pkg::ST_IDLE;
            occ_reg       <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_slot8_reg  <= pend_slot8_next;
        pend_handle_reg <= pend_handle_next;
        pend_rdata_reg  <= pend_rdata_next;
        pend_last_reg   <= pend_last_next;
        pend_clear_reg  <= pend_clear_next;
        status_reg      <= status_next;
        slot_out_reg    <= slot_out_next;
        handle_out_reg  <= handle_out_next;
        last_reg        <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_out   = slot_out_reg;
    assign handle_out = handle_out_reg;
    assign last       = last_reg;

    `DST_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_reg != dst_pkg::ST_IDLE,
        "request accepted but control stayed idle")
    `DST_ASSERT_NOW(a_hint_in_range, 1'b1, hint_reg <= TW'(NS),
        "free hint beyond table capacity")
    `DST_ASSERT_NOW(a_ok_has_handle, out_valid_reg && status_reg == dst_pkg::STAT_OK,
        handle_out_reg != '0, "ok result with empty handle")
    `DST_ASSERT_NEXT(a_clear_slot_dropped, state_reg == dst_pkg::ST_CLR_FIND,
        !occ_reg[pend_slot_reg], "cleared slot still marked occupied")

endmodule
